FILE: rtl/b32d_pkg.sv
`default_nettype none

package b32d_pkg;

   localparam int unsigned SymbolCount = 32;
   localparam int unsigned GroupWidth  = 5;

   // Upper-case alphabet without L and O; the first symbol sits in the top byte.
   localparam logic [8*SymbolCount-1:0] Symbols = "ABCDEFGHIJKMNPQRSTUVWXYZ23456789";

   // One classified character on its way from the front end to the back end.
   typedef struct packed {
      logic [GroupWidth-1:0] group;
      logic                  bad;
      logic                  last;
   } b32d_item_type;

   // Folds lower case to upper case and looks the character up in the alphabet.
   function automatic b32d_item_type classify(input logic [7:0] ch, input logic last);
      logic [7:0]    folded;
      b32d_item_type item;
      folded     = ((ch >= 8'h61) && (ch <= 8'h7A)) ? (ch - 8'h20) : ch;
      item.group = '0;
      item.bad   = 1'b1;
      item.last  = last;
      for (int k = 0; k < SymbolCount; k++) begin
         if (Symbols[8*(SymbolCount-1-k) +: 8] == folded) begin
            item.group = GroupWidth'(k);
            item.bad   = 1'b0;
         end
      end
      return item;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/base32_custom_decoder_unit.sv
// Base32 decoder for the 32-symbol alphabet without L and O, either case.
// The req channel takes one character per beat on req_tdata, with req_tlast
// on the final character of a string. The rsp channel returns at most one
// beat per character: a decoded byte whenever eight bits are complete, and
// always one beat for the last character, marked by rsp_tlast. rsp_tuser[0]
// says the byte is valid; rsp_tuser[1] flags a character outside the
// alphabet, after which the string's remaining characters are skipped up to
// its last one, whose beat also carries the flag.
// Throughput is one character per cycle while rsp_tready stays high. Each
// accepted character is registered in the classifying stage, then in the
// queue, and its result then in the back end's output register.
// When rsp_tready is low the output register holds its beat; the back end
// stops and the queue of QUEUE_DEPTH entries (a power of two, at least two)
// absorbs further characters before req_tready falls.
// Synchronous reset empties the pipeline and clears the bit accumulator and
// the error flag; no clearing pass is needed.
`default_nettype none

module base32_custom_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // character
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // data_byte
   output logic            rsp_tlast,
   output logic [1:0]      rsp_tuser    // byte_valid, bad_character
);
   import b32d_pkg::*;

   logic          front_valid;
   logic          front_ready;
   b32d_item_type front_item;
   logic          back_valid;
   logic          back_ready;
   b32d_item_type back_item;

   b32d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   b32d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   b32d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item       (back_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: rtl/b32d_front.sv
`default_nettype none

module b32d_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,
   input  wire logic                   req_tlast,
   output logic                        item_valid,
   input  wire logic                   item_ready,
   output b32d_pkg::b32d_item_type     item
);
   import b32d_pkg::*;

   logic          stage_valid_ff;
   logic          stage_valid_in;
   b32d_item_type stage_item_ff;
   b32d_item_type stage_item_in;
   logic          take;

   // The stage reloads whenever it is empty or its item moves on this cycle.
   assign req_tready = !stage_valid_ff || item_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_item_in  = stage_item_ff;
      if (take) begin
         stage_valid_in = 1'b1;
         stage_item_in  = classify(req_tdata, req_tlast);
      end else if (item_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_item_ff <= stage_item_in;
   end

   assign item_valid = stage_valid_ff;
   assign item       = stage_item_ff;

endmodule

`default_nettype wire

FILE: rtl/b32d_queue.sv
`default_nettype none

module b32d_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   output logic                        push_ready,
   input  wire b32d_pkg::b32d_item_type push_item,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output b32d_pkg::b32d_item_type     pop_item
);
   import b32d_pkg::*;

   localparam int unsigned AddrWidth  = $clog2(DEPTH);
   localparam int unsigned CountWidth = AddrWidth + 1;

   b32d_item_type             entries_ff [DEPTH];
   logic [AddrWidth-1:0]      wr_ptr_ff;
   logic [AddrWidth-1:0]      wr_ptr_in;
   logic [AddrWidth-1:0]      rd_ptr_ff;
   logic [AddrWidth-1:0]      rd_ptr_in;
   logic [CountWidth-1:0]     count_ff;
   logic [CountWidth-1:0]     count_in;
   logic                      do_push;
   logic                      do_pop;

   assign push_ready = (count_ff != CountWidth'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = entries_ff[rd_ptr_ff];

   // Pointers wrap naturally, so the user must keep DEPTH a power of two of at least two; nothing checks it.
   always_comb begin
      wr_ptr_in = do_push ? (wr_ptr_ff + AddrWidth'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? (rd_ptr_ff + AddrWidth'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/b32d_back.sv
`default_nettype none

module b32d_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_valid,
   output logic                        item_ready,
   input  wire b32d_pkg::b32d_item_type item,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tlast,
   output logic [1:0]                  rsp_tuser
);
   import b32d_pkg::*;

   logic [6:0]  pending_bits_ff;
   logic [6:0]  pending_bits_in;
   logic [2:0]  pending_count_ff;
   logic [2:0]  pending_count_in;
   logic        error_seen_ff;
   logic        error_seen_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [7:0]  out_byte_ff;
   logic [7:0]  out_byte_in;
   logic        out_byte_valid_ff;
   logic        out_byte_valid_in;
   logic        out_end_ff;
   logic        out_end_in;
   logic        out_bad_ff;
   logic        out_bad_in;
   logic        pop;
   logic        has_result;
   logic [11:0] acc;
   logic [3:0]  count;
   logic [2:0]  rest;
   logic [6:0]  rest_mask;

   // An item is consumed whenever the output register is free or being emptied.
   assign item_ready = !out_valid_ff || rsp_tready;
   assign pop        = item_valid && item_ready;

   assign acc       = {pending_bits_ff, item.group};
   assign count     = {1'b0, pending_count_ff} + 4'd5;
   assign rest      = count[2:0];
   assign rest_mask = (7'd1 << rest) - 7'd1;

   always_comb begin
      pending_bits_in   = pending_bits_ff;
      pending_count_in  = pending_count_ff;
      error_seen_in     = error_seen_ff;
      has_result        = 1'b0;
      out_byte_in       = out_byte_ff;
      out_byte_valid_in = out_byte_valid_ff;
      out_end_in        = out_end_ff;
      out_bad_in        = out_bad_ff;

      if (pop) begin
         out_byte_in       = 8'd0;
         out_byte_valid_in = 1'b0;
         out_end_in        = item.last;
         out_bad_in        = 1'b0;
         if (error_seen_ff) begin
            // The rest of a broken string is skipped until its last character.
            has_result = item.last;
            out_bad_in = 1'b1;
         end else if (item.bad) begin
            has_result    = 1'b1;
            out_bad_in    = 1'b1;
            error_seen_in = 1'b1;
         end else if (count[3]) begin
            has_result        = 1'b1;
            out_byte_in       = 8'(acc >> rest);
            out_byte_valid_in = 1'b1;
            pending_bits_in   = acc[6:0] & rest_mask;
            pending_count_in  = rest;
         end else begin
            has_result       = item.last;
            pending_bits_in  = acc[6:0];
            pending_count_in = count[2:0];
         end
         if (item.last) begin
            pending_bits_in  = '0;
            pending_count_in = '0;
            error_seen_in    = 1'b0;
         end
      end
   end

   always_comb begin
      if (pop) begin
         out_valid_in = has_result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bits_ff  <= '0;
         pending_count_ff <= '0;
         error_seen_ff    <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
         error_seen_ff    <= error_seen_in;
         out_valid_ff     <= out_valid_in;
      end
      out_byte_ff       <= out_byte_in;
      out_byte_valid_ff <= out_byte_valid_in;
      out_end_ff        <= out_end_in;
      out_bad_ff        <= out_bad_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_end_ff;
   assign rsp_tuser  = {out_bad_ff, out_byte_valid_ff};

endmodule

`default_nettype wire
